// ===== rtl/dtf_pkg.sv =====
// Shared types, constants and float32 helper functions for the decimal text parser.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package dtf_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] F32_ZERO  = 32'h0000_0000;
    localparam logic [31:0] F32_TENTH = 32'h3DCC_CCCD;
    localparam logic [31:0] F32_TEN   = 32'h4120_0000;
    localparam logic [31:0] F32_INF   = 32'h7F80_0000;

    localparam int unsigned MAX_LENGTH = 65535;
    // Count stops at the smaller of MAX_LENGTH and the 16-bit field maximum
    localparam logic [15:0] COUNT_CAP  = (MAX_LENGTH < 65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SIGNED,
        PH_WHOLE,
        PH_FRACTION
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WHOLE,
        OP_FRAC,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_WMUL,
        B_WMULW,
        B_WADD,
        B_WADDW,
        B_FMUL,
        B_FMULW,
        B_FADD,
        B_FADDW,
        B_EADD,
        B_EADDW,
        B_EOUT
    } back_state_t;

    typedef struct packed {
        logic        clr;
        op_t         op;
        logic [3:0]  digit;
        logic        ok;
        logic        neg;
        logic [15:0] count;
    } op_entry_t;

    typedef struct packed {
        logic mul_go;
        logic add_go;
    } fpu_req_t;

    typedef struct packed {
        logic mul_done;
        logic add_done;
    } fpu_rsp_t;

    function automatic logic [31:0] digit_to_f32(input logic [3:0] d);
        logic [31:0] res;
        unique case (d)
            4'd0:    res = 32'h0000_0000;
            4'd1:    res = 32'h3F80_0000;
            4'd2:    res = 32'h4000_0000;
            4'd3:    res = 32'h4040_0000;
            4'd4:    res = 32'h4080_0000;
            4'd5:    res = 32'h40A0_0000;
            4'd6:    res = 32'h40C0_0000;
            4'd7:    res = 32'h40E0_0000;
            4'd8:    res = 32'h4100_0000;
            4'd9:    res = 32'h4110_0000;
            default: res = 32'h0000_0000;
        endcase
        return res;
    endfunction

    // Round sig * 2^expo to float32, nearest even, with subnormals and overflow to inf.
    function automatic logic [31:0] fp_round(input logic [51:0] sig,
                                             input logic signed [11:0] expo);
        logic [5:0]         top;
        logic signed [12:0] top_e;
        logic signed [12:0] lsb_e;
        logic signed [12:0] sh;
        logic signed [12:0] bexp;
        logic [51:0]        kept;
        logic [51:0]        low_mask;
        logic [5:0]         sh_idx;
        logic               guard;
        logic               sticky;
        logic [24:0]        mant;
        logic [31:0]        res;
        top = '0;
        for (int i = 0; i < 52; i++) begin
            if (sig[i]) begin
                top = 6'(i);
            end
        end
        top_e = 13'(expo) + $signed({7'b0, top});
        lsb_e = top_e - 13'sd23;
        if (lsb_e < -13'sd149) begin
            lsb_e = -13'sd149;
        end
        sh       = lsb_e - 13'(expo);
        kept     = '0;
        guard    = 1'b0;
        sticky   = 1'b0;
        low_mask = '0;
        sh_idx   = '0;
        if (sh <= 13'sd0) begin
            kept = sig << 6'(-sh);
        end else if (sh > 13'sd52) begin
            sticky = |sig;
        end else begin
            sh_idx   = 6'(sh - 13'sd1);
            kept     = sig >> 6'(sh);
            guard    = sig[sh_idx];
            low_mask = (52'd1 << sh_idx) - 52'd1;
            sticky   = |(sig & low_mask);
        end
        mant = kept[24:0] + {24'd0, guard & (sticky | kept[0])};
        if (mant[24]) begin
            mant  = mant >> 1;
            lsb_e = lsb_e + 13'sd1;
        end
        bexp = lsb_e + 13'sd150;
        if (sig == '0) begin
            res = F32_ZERO;
        end else if (top_e > 13'sd127 || bexp >= 13'sd255) begin
            res = F32_INF;
        end else if (mant[23]) begin
            res = {1'b0, bexp[7:0], mant[22:0]};
        end else begin
            res = {9'b0, mant[22:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/decimal_text_to_float32.sv =====
// Top level of the decimal text to float32 parser: front end, operation queue, back end.
// Depends on dtf_pkg, dtf_front, dtf_queue, dtf_back.
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_valid / s_ready | s_begin_req, s_buffer_end, s_ch
//   m_      | out       | m_valid / m_ready | m_number_written, m_consumed, m_value_bits
//
// The front end takes one character per cycle while the 4-entry queue has room.
// Signs, points and ignored items need no float work; a digit (integer or fraction)
// holds the back end for a multiply then an add, an end-of-number for an add and the
// output load, a failed sign for the load alone; float steps wait on the 2-stage units.
// Reset (aresetn low, synchronous) returns to idle awaiting a begin item.
// A stalled m_ready holds the result register; the queue keeps filling behind it.
`default_nettype none

module decimal_text_to_float32 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_begin_req,
    input  wire logic        s_buffer_end,
    input  wire logic [7:0]  s_ch,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_number_written,
    output logic [15:0]      m_consumed,
    output logic [31:0]      m_value_bits
);

    dtf_pkg::op_entry_t push_entry, pop_entry;
    logic               push_valid, q_full, q_valid, q_pop;

    assign s_ready = !q_full;

    dtf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_valid && s_ready),
        .s_begin_req  (s_begin_req),
        .s_buffer_end (s_buffer_end),
        .s_ch         (s_ch),
        .push_entry   (push_entry),
        .push_valid   (push_valid)
    );

    dtf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (pop_entry)
    );

    dtf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_entry          (pop_entry),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_number_written (m_number_written),
        .m_consumed       (m_consumed),
        .m_value_bits     (m_value_bits)
    );

endmodule

`default_nettype wire

// ===== rtl/dtf_front.sv =====
// Front end: accepts characters, tracks parse phase, sign and count, and issues operations.
// Depends on dtf_pkg.
`default_nettype none

module dtf_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              s_begin_req,
    input  wire logic              s_buffer_end,
    input  wire logic [7:0]        s_ch,
    output dtf_pkg::op_entry_t     push_entry,
    output logic                   push_valid
);

    dtf_pkg::phase_t phase_reg, phase_next;
    logic            neg_reg, neg_next;
    logic [15:0]     count_reg, count_next;

    dtf_pkg::phase_t phase_eff;
    logic            neg_eff;
    logic [15:0]     count_eff;
    logic [15:0]     count_inc;
    logic            is_digit;
    logic            is_sign;
    logic            is_point;

    always_comb begin
        phase_eff = s_begin_req ? dtf_pkg::PH_START : phase_reg;
        neg_eff   = s_begin_req ? 1'b0 : neg_reg;
        count_eff = s_begin_req ? 16'd0 : count_reg;
        count_inc = (count_eff < dtf_pkg::COUNT_CAP) ? count_eff + 16'd1 : count_eff;
        is_digit  = !s_buffer_end && s_ch >= dtf_pkg::CH_ZERO && s_ch <= dtf_pkg::CH_NINE;
        is_sign   = !s_buffer_end && (s_ch == dtf_pkg::CH_PLUS || s_ch == dtf_pkg::CH_MINUS);
        is_point  = !s_buffer_end && s_ch == dtf_pkg::CH_POINT;
    end

    // Next-state logic
    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        if (accept) begin
            phase_next = phase_eff;
            neg_next   = neg_eff;
            count_next = count_eff;
            unique case (phase_eff)
                dtf_pkg::PH_IDLE: begin
                end
                dtf_pkg::PH_START: begin
                    if (is_sign) begin
                        neg_next   = (s_ch == dtf_pkg::CH_MINUS);
                        count_next = count_inc;
                        phase_next = dtf_pkg::PH_SIGNED;
                    end else if (is_point) begin
                        count_next = count_inc;
                        phase_next = dtf_pkg::PH_FRACTION;
                    end else if (is_digit) begin
                        count_next = count_inc;
                        phase_next = dtf_pkg::PH_WHOLE;
                    end else begin
                        phase_next = dtf_pkg::PH_IDLE;
                    end
                end
                dtf_pkg::PH_SIGNED: begin
                    if (is_digit) begin
                        count_next = count_inc;
                        phase_next = dtf_pkg::PH_WHOLE;
                    end else begin
                        phase_next = dtf_pkg::PH_IDLE;
                    end
                end
                dtf_pkg::PH_WHOLE: begin
                    if (is_digit) begin
                        count_next = count_inc;
                    end else if (is_point) begin
                        count_next = count_inc;
                        phase_next = dtf_pkg::PH_FRACTION;
                    end else begin
                        phase_next = dtf_pkg::PH_IDLE;
                    end
                end
                dtf_pkg::PH_FRACTION: begin
                    if (is_digit) begin
                        count_next = count_inc;
                    end else begin
                        phase_next = dtf_pkg::PH_IDLE;
                    end
                end
                default: phase_next = dtf_pkg::PH_IDLE;
            endcase
        end
    end

    // Operation issue
    always_comb begin
        push_entry.clr   = s_begin_req;
        push_entry.op    = dtf_pkg::OP_NONE;
        push_entry.digit = s_ch[3:0];
        push_entry.ok    = 1'b1;
        push_entry.neg   = neg_eff;
        push_entry.count = count_eff;
        unique case (phase_eff)
            dtf_pkg::PH_IDLE: begin
            end
            dtf_pkg::PH_START: begin
                if (is_digit) begin
                    push_entry.op = dtf_pkg::OP_WHOLE;
                end else if (!is_sign && !is_point) begin
                    push_entry.op = dtf_pkg::OP_EMIT;
                end
            end
            dtf_pkg::PH_SIGNED: begin
                if (is_digit) begin
                    push_entry.op = dtf_pkg::OP_WHOLE;
                end else begin
                    push_entry.op = dtf_pkg::OP_EMIT;
                    push_entry.ok = 1'b0;
                end
            end
            dtf_pkg::PH_WHOLE: begin
                if (is_digit) begin
                    push_entry.op = dtf_pkg::OP_WHOLE;
                end else if (!is_point) begin
                    push_entry.op = dtf_pkg::OP_EMIT;
                end
            end
            dtf_pkg::PH_FRACTION: begin
                push_entry.op = is_digit ? dtf_pkg::OP_FRAC : dtf_pkg::OP_EMIT;
            end
            default: push_entry.op = dtf_pkg::OP_NONE;
        endcase
        push_valid = accept && (push_entry.clr || push_entry.op != dtf_pkg::OP_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dtf_pkg::PH_IDLE;
            neg_reg   <= 1'b0;
            count_reg <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dtf_queue.sv =====
// Short operation queue between front end and back end.
// Depends on dtf_pkg.
`default_nettype none

module dtf_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  dtf_pkg::op_entry_t      push_entry,
    output logic                    full,
    output logic                    pop_valid,
    input  wire logic               pop,
    output dtf_pkg::op_entry_t      pop_entry
);

    dtf_pkg::op_entry_t entries_reg [dtf_pkg::QUEUE_DEPTH];
    logic [dtf_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dtf_pkg::QUEUE_AW:0]   fill_reg, fill_next;
    logic                         do_push, do_pop;

    always_comb begin
        full      = (fill_reg == (dtf_pkg::QUEUE_AW+1)'(dtf_pkg::QUEUE_DEPTH));
        pop_valid = (fill_reg != '0);
        pop_entry = entries_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && pop_valid;
        fill_next = fill_reg + {{dtf_pkg::QUEUE_AW{1'b0}}, do_push}
                    - {{dtf_pkg::QUEUE_AW{1'b0}}, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dtf_fpu.sv =====
// Float32 multiplier and adder for non-negative operands, two stages each, fixed latency.
// Depends on dtf_pkg (fp_round).
`default_nettype none

module dtf_fpu (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  dtf_pkg::fpu_req_t  req,
    input  wire logic [31:0]   mul_a,
    input  wire logic [31:0]   mul_b,
    input  wire logic [31:0]   add_a,
    input  wire logic [31:0]   add_b,
    output dtf_pkg::fpu_rsp_t  rsp,
    output logic [31:0]        mul_res,
    output logic [31:0]        add_res
);

    logic [23:0]        ma, mb;
    logic [7:0]         ea, eb;
    logic [47:0]        prod_next;
    logic signed [11:0] pexp_next;

    logic [47:0]        prod_reg;
    logic signed [11:0] pexp_reg;
    logic               pinf_reg;
    logic               mv1_reg, mv2_reg;
    logic [31:0]        mul_res_reg;

    logic [31:0]        big, minor;
    logic [23:0]        mbig, mminor;
    logic [7:0]         ebig, eminor, ediff;
    logic [51:0]        sum_next;
    logic signed [11:0] sexp_next;

    logic [51:0]        sum_reg;
    logic signed [11:0] sexp_reg;
    logic               sinf_reg;
    logic               av1_reg, av2_reg;
    logic [31:0]        add_res_reg;

    // Stage 1 multiply: integer significand product
    always_comb begin
        ma        = {mul_a[30:23] != 8'd0, mul_a[22:0]};
        mb        = {mul_b[30:23] != 8'd0, mul_b[22:0]};
        ea        = (mul_a[30:23] == 8'd0) ? 8'd1 : mul_a[30:23];
        eb        = (mul_b[30:23] == 8'd0) ? 8'd1 : mul_b[30:23];
        prod_next = ma * mb;
        pexp_next = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300;
    end

    // Stage 1 add: align the larger operand to the smaller's exponent, a far smaller operand folds into a sticky bit
    always_comb begin
        if (add_a[30:0] >= add_b[30:0]) begin
            big   = add_a;
            minor = add_b;
        end else begin
            big   = add_b;
            minor = add_a;
        end
        mbig   = {big[30:23] != 8'd0, big[22:0]};
        mminor = {minor[30:23] != 8'd0, minor[22:0]};
        ebig   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eminor = (minor[30:23] == 8'd0) ? 8'd1 : minor[30:23];
        ediff  = ebig - eminor;
        if (ediff > 8'd27) begin
            sum_next  = ({28'd0, mbig} << 27) + {51'd0, mminor != 24'd0};
            sexp_next = $signed({4'b0, ebig}) - 12'sd177;
        end else begin
            sum_next  = ({28'd0, mbig} << ediff[4:0]) + {28'd0, mminor};
            sexp_next = $signed({4'b0, eminor}) - 12'sd150;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        pexp_reg    <= pexp_next;
        pinf_reg    <= (mul_a[30:23] == 8'hFF) || (mul_b[30:23] == 8'hFF);
        mul_res_reg <= pinf_reg ? dtf_pkg::F32_INF : dtf_pkg::fp_round({4'd0, prod_reg}, pexp_reg);
        sum_reg     <= sum_next;
        sexp_reg    <= sexp_next;
        sinf_reg    <= (add_a[30:23] == 8'hFF) || (add_b[30:23] == 8'hFF);
        add_res_reg <= sinf_reg ? dtf_pkg::F32_INF : dtf_pkg::fp_round(sum_reg, sexp_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv1_reg <= 1'b0;
            mv2_reg <= 1'b0;
            av1_reg <= 1'b0;
            av2_reg <= 1'b0;
        end else begin
            mv1_reg <= req.mul_go;
            mv2_reg <= mv1_reg;
            av1_reg <= req.add_go;
            av2_reg <= av1_reg;
        end
    end

    assign rsp.mul_done = mv2_reg;
    assign rsp.add_done = av2_reg;
    assign mul_res      = mul_res_reg;
    assign add_res      = add_res_reg;

endmodule

`default_nettype wire

// ===== rtl/dtf_back.sv =====
// Back end: sequences float operations for each queued operation and holds the result register.
// Depends on dtf_pkg and dtf_fpu.
`default_nettype none

module dtf_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  dtf_pkg::op_entry_t     q_entry,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_number_written,
    output logic [15:0]            m_consumed,
    output logic [31:0]            m_value_bits
);

    dtf_pkg::back_state_t state_reg, state_next;

    logic [31:0] whole_reg, frac_reg, weight_reg, tmp_reg, digit_reg;
    logic        ok_reg, neg_reg;
    logic [15:0] count_reg;

    logic        out_valid_reg;
    logic        out_written_reg;
    logic [15:0] out_consumed_reg;
    logic [31:0] out_bits_reg;

    dtf_pkg::fpu_req_t fpu_req;
    dtf_pkg::fpu_rsp_t fpu_rsp;
    logic [31:0]       mul_a, mul_b, add_a, add_b, mul_res, add_res;
    logic              out_free;
    logic              out_load;

    dtf_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .add_a   (add_a),
        .add_b   (add_b),
        .rsp     (fpu_rsp),
        .mul_res (mul_res),
        .add_res (add_res)
    );

    assign out_free = !out_valid_reg || m_ready;

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtf_pkg::B_IDLE: begin
                if (q_valid) begin
                    unique case (q_entry.op)
                        dtf_pkg::OP_NONE:  state_next = dtf_pkg::B_IDLE;
                        dtf_pkg::OP_WHOLE: state_next = dtf_pkg::B_WMUL;
                        dtf_pkg::OP_FRAC:  state_next = dtf_pkg::B_FMUL;
                        dtf_pkg::OP_EMIT:  state_next = q_entry.ok ? dtf_pkg::B_EADD
                                                                   : dtf_pkg::B_EOUT;
                        default:           state_next = dtf_pkg::B_IDLE;
                    endcase
                end
            end
            dtf_pkg::B_WMUL:  state_next = dtf_pkg::B_WMULW;
            dtf_pkg::B_WMULW: if (fpu_rsp.mul_done) state_next = dtf_pkg::B_WADD;
            dtf_pkg::B_WADD:  state_next = dtf_pkg::B_WADDW;
            dtf_pkg::B_WADDW: if (fpu_rsp.add_done) state_next = dtf_pkg::B_IDLE;
            dtf_pkg::B_FMUL:  state_next = dtf_pkg::B_FMULW;
            dtf_pkg::B_FMULW: if (fpu_rsp.mul_done) state_next = dtf_pkg::B_FADD;
            dtf_pkg::B_FADD:  state_next = dtf_pkg::B_FADDW;
            dtf_pkg::B_FADDW: if (fpu_rsp.add_done) state_next = dtf_pkg::B_IDLE;
            dtf_pkg::B_EADD:  state_next = dtf_pkg::B_EADDW;
            dtf_pkg::B_EADDW: if (fpu_rsp.add_done) state_next = dtf_pkg::B_EOUT;
            dtf_pkg::B_EOUT:  if (out_free) state_next = dtf_pkg::B_IDLE;
            default:          state_next = dtf_pkg::B_IDLE;
        endcase
    end

    // Output decode
    always_comb begin
        q_pop          = 1'b0;
        fpu_req.mul_go = 1'b0;
        fpu_req.add_go = 1'b0;
        mul_a          = whole_reg;
        mul_b          = dtf_pkg::F32_TEN;
        add_a          = tmp_reg;
        add_b          = digit_reg;
        out_load       = 1'b0;
        unique case (state_reg)
            dtf_pkg::B_IDLE: q_pop = q_valid;
            dtf_pkg::B_WMUL: fpu_req.mul_go = 1'b1;
            dtf_pkg::B_WADD: fpu_req.add_go = 1'b1;
            dtf_pkg::B_FMUL: begin
                fpu_req.mul_go = 1'b1;
                mul_a          = weight_reg;
                mul_b          = digit_reg;
            end
            dtf_pkg::B_FADD: begin
                fpu_req.mul_go = 1'b1;
                fpu_req.add_go = 1'b1;
                mul_a          = weight_reg;
                mul_b          = dtf_pkg::F32_TENTH;
                add_a          = frac_reg;
                add_b          = tmp_reg;
            end
            dtf_pkg::B_EADD: begin
                fpu_req.add_go = 1'b1;
                add_a          = whole_reg;
                add_b          = frac_reg;
            end
            dtf_pkg::B_EOUT: out_load = out_free;
            default: begin
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == dtf_pkg::B_IDLE && q_valid) begin
            digit_reg <= dtf_pkg::digit_to_f32(q_entry.digit);
            ok_reg    <= q_entry.ok;
            neg_reg   <= q_entry.neg;
            count_reg <= q_entry.count;
            if (q_entry.clr) begin
                whole_reg  <= dtf_pkg::F32_ZERO;
                frac_reg   <= dtf_pkg::F32_ZERO;
                weight_reg <= dtf_pkg::F32_TENTH;
            end
        end
        if ((state_reg == dtf_pkg::B_WMULW || state_reg == dtf_pkg::B_FMULW)
            && fpu_rsp.mul_done) begin
            tmp_reg <= mul_res;
        end
        if (state_reg == dtf_pkg::B_WADDW && fpu_rsp.add_done) begin
            whole_reg <= add_res;
        end
        if (state_reg == dtf_pkg::B_FADDW && fpu_rsp.add_done) begin
            frac_reg   <= add_res;
            weight_reg <= mul_res;
        end
        if (state_reg == dtf_pkg::B_EADDW && fpu_rsp.add_done) begin
            tmp_reg <= add_res;
        end
        if (out_load) begin
            out_written_reg  <= ok_reg;
            out_consumed_reg <= ok_reg ? count_reg : 16'd0;
            out_bits_reg     <= ok_reg ? (tmp_reg ^ {neg_reg, 31'd0}) : dtf_pkg::F32_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dtf_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_number_written = out_written_reg;
    assign m_consumed       = out_consumed_reg;
    assign m_value_bits     = out_bits_reg;

`ifndef ASSERT_OFF
    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_rsp.mul_done |-> (state_reg == dtf_pkg::B_WMULW || state_reg == dtf_pkg::B_FMULW
                              || state_reg == dtf_pkg::B_FADDW))
        else $error("multiplier result arrived outside a wait state");

    a_add_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_rsp.add_done |-> (state_reg == dtf_pkg::B_WADDW || state_reg == dtf_pkg::B_FADDW
                              || state_reg == dtf_pkg::B_EADDW))
        else $error("adder result arrived outside a wait state");

    a_fail_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_number_written) |-> (m_consumed == 16'd0 && m_value_bits == 32'd0))
        else $error("failure transaction carries nonzero payload");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire
